[hw/rtl/pcl_pkg.sv]
`default_nettype none
package pcl_pkg;

  localparam int DEST_ENTRIES = 16;
  localparam int WAIT_SLOTS   = 64;
  localparam int MAX_OUT      = 64;
  localparam int FQ_DEPTH     = 2;
  localparam int OQ_DEPTH     = 4;

  localparam int DEST_W = $clog2(DEST_ENTRIES);
  localparam int SLOT_W = $clog2(WAIT_SLOTS);
  localparam int FILL_W = $clog2(WAIT_SLOTS + 1);
  localparam int N_W    = $clog2(MAX_OUT + 1);

  localparam logic [15:0] CONN_LIMIT_RESET = 16'd1;
  localparam logic [9:0]  BACKLOG_RESET    = 10'd1000;

  typedef enum logic [1:0] {
    FUNC_REQUEST = 2'd0,
    FUNC_RELEASE = 2'd1,
    FUNC_CANCEL  = 2'd2,
    FUNC_ABANDON = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    V_ADMITTED  = 3'd0,
    V_QUEUED    = 3'd1,
    V_DROPPED   = 3'd2,
    V_RESUMED   = 3'd3,
    V_RELEASED  = 3'd4,
    V_CANCELLED = 3'd5,
    V_TABLEFULL = 3'd6,
    V_NOTFOUND  = 3'd7
  } verdict_e;

  typedef enum logic {
    CFG_CONN_LIMIT = 1'b0,
    CFG_BACKLOG    = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    func_e       func;
    logic [31:0] dest_addr;
    logic [15:0] dest_port;
    logic [15:0] request_tag;
  } in_item_t;

  typedef struct packed {
    verdict_e    verdict;
    logic [15:0] affected_tag;
    logic [15:0] active_now;
    logic [6:0]  waiting_now;
    logic        last;
  } result_t;

  // Classified job handed from the front to the engine.
  typedef struct packed {
    func_e       func;
    logic [47:0] key;
    logic [15:0] tag;
  } job_t;

  typedef struct packed {
    logic [15:0]       tag;
    logic [DEST_W-1:0] dest;
  } waiter_t;

endpackage
`default_nettype wire

[hw/rtl/per_destination_connection_limiter.sv]
// The engine handles one item at a time. It looks up the key in the 16-entry destination
// table one entry per cycle, stopping at a match; cancel and resume walk the waiter ring
// slot by slot and then trim dead slots at its ends, repeated for each resumed waiter
// (up to 64).
// Reset: asynchronous and active low; it empties both queues, the destination table
// and the waiter ring, and sets the limits to 1 and 1000. No clearing pass is needed.
`default_nettype none
module per_destination_connection_limiter import pcl_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire in_item_t    item_i,
  output logic             empty,
  input  wire logic        pop,
  output result_t          result_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);

  // The front queue takes a transfer in every cycle it has room and builds the
  // 48-bit destination key, so the input side keeps taking items while the
  // engine is busy with a long ring walk, until both of its entries are taken.
  logic    fq_empty, fq_pop;
  job_t    job;
  logic    oq_full, oq_push;
  result_t oq_data;

  pcl_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .item_i  (item_i),
    .pop_i   (fq_pop),
    .empty_o (fq_empty),
    .job_o   (job)
  );

  // The engine looks up the destination, then admits, queues, drops, releases, cancels
  // or resumes waiters by walking the shared waiter ring one slot at a time.
  pcl_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .fq_empty_i (fq_empty),
    .job_i      (job),
    .fq_pop_o   (fq_pop),
    .oq_full_i  (oq_full),
    .oq_push_o  (oq_push),
    .oq_data_o  (oq_data)
  );

  // Results wait here until the consumer pops them; the engine keeps going
  // while results are still waiting, up to the queue depth.
  pcl_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (oq_push),
    .data_i (oq_data),
    .full_o (oq_full),
    .pop    (pop),
    .empty  (empty),
    .data_o (result_o)
  );

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oq_push |-> !oq_full)
    else $error("engine wrote a result into a full result queue");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fq_pop |-> !fq_empty)
    else $error("engine took a job from an empty front queue");

  a_waiting_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (result_o.waiting_now <= 7'(WAIT_SLOTS)))
    else $error("reported wait queue length exceeds ring size");

endmodule
`default_nettype wire

[hw/rtl/pcl_front.sv]
`default_nettype none
module pcl_front import pcl_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t item_i,
  input  wire logic     pop_i,
  output logic          empty_o,
  output job_t          job_o
);

  localparam int AW = $clog2(FQ_DEPTH);
  localparam int CW = $clog2(FQ_DEPTH + 1);

  job_t          mem_q [FQ_DEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          push_ok, pop_ok;
  job_t          job_in;

  // The key is formed here so the engine sees one 48-bit compare value.
  always_comb begin
    job_in.func = item_i.func;
    job_in.key  = {item_i.dest_addr, item_i.dest_port};
    job_in.tag  = item_i.request_tag;
  end

  assign full    = (cnt_q == CW'(FQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_ok) begin
      wr_d = (wr_q == AW'(FQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_ok) begin
      rd_d = (rd_q == AW'(FQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_ok && pop_ok) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_q] <= job_in;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/pcl_outq.sv]
`default_nettype none
module pcl_outq import pcl_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire result_t data_i,
  output logic         full_o,
  input  wire logic    pop,
  output logic         empty,
  output result_t      data_o
);

  localparam int AW = $clog2(OQ_DEPTH);
  localparam int CW = $clog2(OQ_DEPTH + 1);

  result_t       mem_q [OQ_DEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          push_ok, pop_ok;

  assign full_o  = (cnt_q == CW'(OQ_DEPTH));
  assign empty   = (cnt_q == '0);
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop && !empty;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_ok) begin
      wr_d = (wr_q == AW'(OQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_ok) begin
      rd_d = (rd_q == AW'(OQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_ok && pop_ok) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/pcl_engine.sv]
`default_nettype none
module pcl_engine import pcl_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        fq_empty_i,
  input  wire job_t        job_i,
  output logic             fq_pop_o,
  input  wire logic        oq_full_i,
  output logic             oq_push_o,
  output result_t          oq_data_o
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_LOOK  = 8'b0000_0010,
    S_DISP  = 8'b0000_0100,
    S_RD    = 8'b0000_1000,
    S_CHK   = 8'b0001_0000,
    S_TRIM  = 8'b0010_0000,
    S_POST  = 8'b0100_0000,
    S_FLUSH = 8'b1000_0000
  } state_e;

  state_e            state_q, state_d;
  logic [15:0]       limit_q, limit_d;
  logic [9:0]        backlog_q, backlog_d;
  job_t              job_q, job_d;
  logic [DEST_W-1:0] scan_q, scan_d, d_q, d_d, free_q, free_d;
  logic              found_q, found_d, free_v_q, free_v_d;
  logic [47:0]       dest_key_q [DEST_ENTRIES];
  logic              dest_valid_q [DEST_ENTRIES];
  logic              dest_valid_d [DEST_ENTRIES];
  logic [15:0]       dest_active_q [DEST_ENTRIES];
  logic [15:0]       dest_active_d [DEST_ENTRIES];
  logic [6:0]        dest_wait_q [DEST_ENTRIES];
  logic [6:0]        dest_wait_d [DEST_ENTRIES];
  logic              key_we;
  logic [WAIT_SLOTS-1:0] live_q, live_d;
  logic [SLOT_W-1:0] head_q, head_d, tail_q, tail_d, pos_q, pos_d;
  logic [FILL_W-1:0] fill_q, fill_d, k_q, k_d;
  logic [N_W-1:0]    n_q, n_d;
  logic [15:0]       wt_q, wt_d;
  result_t           pend_q, pend_d;
  logic              pend_v_q, pend_v_d;
  waiter_t           wmem [WAIT_SLOTS];
  waiter_t           rdata_q, wdata;
  logic              wr_en, rd_en;
  logic              em_v;
  result_t           em;
  logic              can_emit;

  function automatic logic [SLOT_W-1:0] ring_next(input logic [SLOT_W-1:0] i);
    return (i == SLOT_W'(WAIT_SLOTS - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [SLOT_W-1:0] ring_prev(input logic [SLOT_W-1:0] i);
    return (i == '0) ? SLOT_W'(WAIT_SLOTS - 1) : i - 1'b1;
  endfunction

  assign can_emit = !pend_v_q || !oq_full_i;

  always_comb begin
    logic [DEST_W-1:0] dsel;
    logic [15:0]       act, na, a1;
    logic [6:0]        wt;
    logic              hit;
    logic [N_W-1:0]    n1;

    state_d       = state_q;
    limit_d       = limit_q;
    backlog_d     = backlog_q;
    job_d         = job_q;
    scan_d        = scan_q;
    d_d           = d_q;
    free_d        = free_q;
    found_d       = found_q;
    free_v_d      = free_v_q;
    dest_valid_d  = dest_valid_q;
    dest_active_d = dest_active_q;
    dest_wait_d   = dest_wait_q;
    key_we        = 1'b0;
    live_d        = live_q;
    head_d        = head_q;
    tail_d        = tail_q;
    pos_d         = pos_q;
    fill_d        = fill_q;
    k_d           = k_q;
    n_d           = n_q;
    wt_d          = wt_q;
    pend_d        = pend_q;
    pend_v_d      = pend_v_q;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    wdata.tag     = job_q.tag;
    wdata.dest    = d_q;
    fq_pop_o      = 1'b0;
    oq_push_o     = 1'b0;
    oq_data_o     = pend_q;
    em_v          = 1'b0;
    em.verdict    = V_RELEASED;
    em.affected_tag = job_q.tag;
    em.active_now = '0;
    em.waiting_now = '0;
    em.last       = 1'b0;
    dsel          = found_q ? d_q : free_q;
    act           = found_q ? dest_active_q[d_q] : 16'd0;
    wt            = found_q ? dest_wait_q[d_q] : 7'd0;
    na            = (act != 16'd0) ? act - 1'b1 : act;
    a1            = (act != 16'hFFFF) ? act + 1'b1 : act;
    hit           = live_q[pos_q] && (rdata_q.dest == d_q) &&
                    ((job_q.func != FUNC_CANCEL) || (rdata_q.tag == job_q.tag));
    n1            = n_q + 1'b1;

    if (cfg_we_i) begin
      if (cfg_idx_i == CFG_CONN_LIMIT) begin
        limit_d = cfg_data_i;
      end else begin
        backlog_d = cfg_data_i[9:0];
      end
    end

    case (state_q)
      S_IDLE: begin
        if (!fq_empty_i) begin
          fq_pop_o = 1'b1;
          job_d    = job_i;
          scan_d   = '0;
          found_d  = 1'b0;
          free_v_d = 1'b0;
          state_d  = S_LOOK;
        end
      end
      S_LOOK: begin
        if (dest_valid_q[scan_q] && (dest_key_q[scan_q] == job_q.key)) begin
          found_d = 1'b1;
          d_d     = scan_q;
          state_d = S_DISP;
        end else begin
          if (!dest_valid_q[scan_q] && !free_v_q) begin
            free_v_d = 1'b1;
            free_d   = scan_q;
          end
          if (scan_q == DEST_W'(DEST_ENTRIES - 1)) begin
            state_d = S_DISP;
          end else begin
            scan_d = scan_q + 1'b1;
          end
        end
      end
      S_DISP: begin
        if (can_emit) begin
          if (job_q.func == FUNC_REQUEST) begin
            state_d = S_FLUSH;
            if (!found_q && !free_v_q) begin
              em_v       = 1'b1;
              em.verdict = V_TABLEFULL;
            end else begin
              d_d = dsel;
              if (!found_q) begin
                key_we             = 1'b1;
                dest_valid_d[dsel] = 1'b1;
                dest_active_d[dsel] = '0;
                dest_wait_d[dsel]  = '0;
              end
              em_v = 1'b1;
              if ((act >= limit_q) && (act != 16'd0)) begin
                em.active_now = act;
                if (({3'b000, wt} >= backlog_q) || (fill_q == FILL_W'(WAIT_SLOTS))) begin
                  em.verdict     = V_DROPPED;
                  em.waiting_now = wt;
                end else begin
                  wr_en              = 1'b1;
                  wdata.dest         = dsel;
                  live_d[tail_q]     = 1'b1;
                  tail_d             = ring_next(tail_q);
                  fill_d             = fill_q + 1'b1;
                  dest_wait_d[dsel]  = wt + 1'b1;
                  em.verdict         = V_QUEUED;
                  em.waiting_now     = wt + 1'b1;
                end
              end else begin
                dest_active_d[dsel] = a1;
                em.verdict          = V_ADMITTED;
                em.active_now       = a1;
                em.waiting_now      = wt;
              end
            end
          end else if (!found_q) begin
            em_v       = 1'b1;
            em.verdict = V_NOTFOUND;
            state_d    = S_FLUSH;
          end else if (job_q.func == FUNC_CANCEL) begin
            pos_d   = head_q;
            k_d     = '0;
            state_d = S_RD;
          end else begin
            dest_active_d[d_q] = na;
            // Abandon, empty queue, or over the limit and still busy: the slot goes back, nobody resumes.
            if ((job_q.func == FUNC_ABANDON) || (wt == 7'd0) ||
                ((act > limit_q) && (na != 16'd0))) begin
              em_v           = 1'b1;
              em.verdict     = V_RELEASED;
              em.active_now  = na;
              em.waiting_now = wt;
              state_d        = S_FLUSH;
            end else begin
              pos_d   = head_q;
              k_d     = '0;
              n_d     = '0;
              state_d = S_RD;
            end
          end
        end
      end
      S_RD: begin
        if (can_emit) begin
          if (k_q == fill_q) begin
            state_d = S_FLUSH;
            if (job_q.func == FUNC_CANCEL) begin
              em_v           = 1'b1;
              em.verdict     = V_NOTFOUND;
              em.active_now  = act;
              em.waiting_now = wt;
            end else begin
              dest_wait_d[d_q] = '0;
              if (n_q == '0) begin
                em_v          = 1'b1;
                em.verdict    = V_RELEASED;
                em.active_now = act;
              end
            end
          end else begin
            rd_en   = 1'b1;
            state_d = S_CHK;
          end
        end
      end
      S_CHK: begin
        if (hit) begin
          live_d[pos_q] = 1'b0;
          wt_d          = rdata_q.tag;
          if (wt != 7'd0) begin
            dest_wait_d[d_q] = wt - 1'b1;
          end
          state_d = S_TRIM;
        end else begin
          pos_d   = ring_next(pos_q);
          k_d     = k_q + 1'b1;
          state_d = S_RD;
        end
      end
      S_TRIM: begin
        if ((fill_q != '0) && !live_q[head_q]) begin
          head_d = ring_next(head_q);
          fill_d = fill_q - 1'b1;
        end else if ((fill_q != '0) && !live_q[ring_prev(tail_q)]) begin
          tail_d = ring_prev(tail_q);
          fill_d = fill_q - 1'b1;
        end else begin
          state_d = S_POST;
        end
      end
      S_POST: begin
        if (can_emit) begin
          em_v           = 1'b1;
          em.waiting_now = wt;
          if (job_q.func == FUNC_CANCEL) begin
            em.verdict    = V_CANCELLED;
            em.active_now = act;
            state_d       = S_FLUSH;
          end else begin
            dest_active_d[d_q] = a1;
            em.verdict         = V_RESUMED;
            em.affected_tag    = wt_q;
            em.active_now      = a1;
            n_d                = n1;
            if ((a1 < limit_q) && (wt != 7'd0) && (n1 < N_W'(MAX_OUT))) begin
              pos_d   = head_q;
              k_d     = '0;
              state_d = S_RD;
            end else begin
              state_d = S_FLUSH;
            end
          end
        end
      end
      S_FLUSH: begin
        if (!oq_full_i) begin
          oq_push_o      = 1'b1;
          oq_data_o.last = 1'b1;
          pend_v_d       = 1'b0;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A result waits in the pending register until it is known
    // whether it is the final one of its item.
    if (em_v) begin
      if (pend_v_q) begin
        oq_push_o      = 1'b1;
        oq_data_o.last = 1'b0;
      end
      pend_d   = em;
      pend_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      limit_q   <= CONN_LIMIT_RESET;
      backlog_q <= BACKLOG_RESET;
      found_q   <= 1'b0;
      free_v_q  <= 1'b0;
      scan_q    <= '0;
      d_q       <= '0;
      free_q    <= '0;
      for (int i = 0; i < DEST_ENTRIES; i++) begin
        dest_valid_q[i]  <= 1'b0;
        dest_active_q[i] <= '0;
        dest_wait_q[i]   <= '0;
      end
      live_q   <= '0;
      head_q   <= '0;
      tail_q   <= '0;
      fill_q   <= '0;
      pos_q    <= '0;
      k_q      <= '0;
      n_q      <= '0;
      pend_v_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      limit_q       <= limit_d;
      backlog_q     <= backlog_d;
      found_q       <= found_d;
      free_v_q      <= free_v_d;
      scan_q        <= scan_d;
      d_q           <= d_d;
      free_q        <= free_d;
      dest_valid_q  <= dest_valid_d;
      dest_active_q <= dest_active_d;
      dest_wait_q   <= dest_wait_d;
      live_q        <= live_d;
      head_q        <= head_d;
      tail_q        <= tail_d;
      fill_q        <= fill_d;
      pos_q         <= pos_d;
      k_q           <= k_d;
      n_q           <= n_d;
      pend_v_q      <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    wt_q   <= wt_d;
    pend_q <= pend_d;
    if (key_we) begin
      dest_key_q[d_d] <= job_q.key;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      wmem[tail_q] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= wmem[pos_q];
    end
  end

endmodule
`default_nettype wire

[verif/tb_per_destination_connection_limiter.sv]
`default_nettype none
module tb_per_destination_connection_limiter;
  timeunit 1ns;
  timeprecision 1ps;
  import pcl_pkg::*;

  // Scoreboard: keeps its own copy of the destination table and the shared
  // waiter ring, works out every result an accepted input should cause and
  // compares the results that the block hands out against that list.
  class limiter_scoreboard;
    logic [47:0] key_tab[DEST_ENTRIES];
    bit          key_used[DEST_ENTRIES];
    int unsigned conn_cnt[DEST_ENTRIES];
    int unsigned wait_cnt[DEST_ENTRIES];
    logic [15:0] slot_tag[WAIT_SLOTS];
    int unsigned slot_dest[WAIT_SLOTS];
    bit          slot_live[WAIT_SLOTS];
    int unsigned head, tail, fill;
    int unsigned conn_limit, backlog_limit;
    result_t     expected_q[$];
    int          errors;

    function void clear();
      for (int i = 0; i < DEST_ENTRIES; i++) begin
        key_used[i] = 0;
        conn_cnt[i] = 0;
        wait_cnt[i] = 0;
      end
      for (int i = 0; i < WAIT_SLOTS; i++) slot_live[i] = 0;
      head = 0;
      tail = 0;
      fill = 0;
      conn_limit = CONN_LIMIT_RESET;
      backlog_limit = BACKLOG_RESET;
      expected_q.delete();
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [15:0] value);
      if (idx == CFG_CONN_LIMIT) conn_limit = value;
      else backlog_limit = value[9:0];
    endfunction

    function int unsigned next_slot(int unsigned i);
      return (i + 1 >= WAIT_SLOTS) ? 0 : i + 1;
    endfunction

    function int unsigned prev_slot(int unsigned i);
      return (i == 0) ? WAIT_SLOTS - 1 : i - 1;
    endfunction

    // Dead slots at either end of the ring are given back right away.
    function void trim_ring();
      while (fill > 0 && !slot_live[head]) begin
        head = next_slot(head);
        fill--;
      end
      while (fill > 0 && !slot_live[prev_slot(tail)]) begin
        tail = prev_slot(tail);
        fill--;
      end
    endfunction

    // Oldest live waiter of a destination, optionally matching a tag too.
    function int oldest_waiter(int unsigned d, bit by_tag, logic [15:0] tag);
      int unsigned pos;
      pos = head;
      for (int unsigned k = 0; k < fill; k++) begin
        if (slot_live[pos] && slot_dest[pos] == d && (!by_tag || slot_tag[pos] == tag))
          return pos;
        pos = next_slot(pos);
      end
      return -1;
    endfunction

    function void add_result(verdict_e v, logic [15:0] tag, int unsigned act,
                             int unsigned waiting);
      result_t r;
      r.verdict = v;
      r.affected_tag = tag;
      r.active_now = (act > 16'hFFFF) ? 16'hFFFF : act[15:0];
      r.waiting_now = waiting[6:0];
      r.last = 1'b0;
      expected_q.push_back(r);
    endfunction

    function void note_input(in_item_t it);
      logic [47:0] key;
      int          d;
      int          w;
      int unsigned n;
      int unsigned prior;
      logic [15:0] wt;
      key = {it.dest_addr, it.dest_port};
      d = -1;
      n = 0;
      for (int i = 0; i < DEST_ENTRIES; i++)
        if (d < 0 && key_used[i] && key_tab[i] == key) d = i;

      if (it.func == FUNC_REQUEST) begin
        if (d < 0) begin
          for (int i = 0; i < DEST_ENTRIES; i++)
            if (d < 0 && !key_used[i]) d = i;
          if (d >= 0) begin
            key_used[d] = 1;
            key_tab[d] = key;
            conn_cnt[d] = 0;
            wait_cnt[d] = 0;
          end
        end
        if (d < 0) begin
          add_result(V_TABLEFULL, it.request_tag, 0, 0);
        end else if (conn_cnt[d] >= conn_limit && conn_cnt[d] != 0) begin
          if (wait_cnt[d] >= backlog_limit || fill >= WAIT_SLOTS) begin
            add_result(V_DROPPED, it.request_tag, conn_cnt[d], wait_cnt[d]);
          end else begin
            slot_tag[tail] = it.request_tag;
            slot_dest[tail] = d;
            slot_live[tail] = 1;
            tail = next_slot(tail);
            fill++;
            wait_cnt[d]++;
            add_result(V_QUEUED, it.request_tag, conn_cnt[d], wait_cnt[d]);
          end
        end else begin
          if (conn_cnt[d] < 16'hFFFF) conn_cnt[d]++;
          add_result(V_ADMITTED, it.request_tag, conn_cnt[d], wait_cnt[d]);
        end
      end else if (d < 0) begin
        add_result(V_NOTFOUND, it.request_tag, 0, 0);
      end else if (it.func == FUNC_CANCEL) begin
        w = oldest_waiter(d, 1, it.request_tag);
        if (w < 0) begin
          add_result(V_NOTFOUND, it.request_tag, conn_cnt[d], wait_cnt[d]);
        end else begin
          slot_live[w] = 0;
          if (wait_cnt[d] > 0) wait_cnt[d]--;
          trim_ring();
          add_result(V_CANCELLED, it.request_tag, conn_cnt[d], wait_cnt[d]);
        end
      end else begin
        prior = conn_cnt[d];
        if (conn_cnt[d] > 0) conn_cnt[d]--;
        // An abandon, an empty queue, or an entry that was over its limit and
        // is still busy gives a plain release without handing on the slot.
        if (it.func == FUNC_ABANDON || wait_cnt[d] == 0 ||
            (prior > conn_limit && conn_cnt[d] != 0)) begin
          add_result(V_RELEASED, it.request_tag, conn_cnt[d], wait_cnt[d]);
        end else begin
          do begin
            w = oldest_waiter(d, 0, '0);
            if (w < 0) begin
              wait_cnt[d] = 0;
              break;
            end
            wt = slot_tag[w];
            slot_live[w] = 0;
            wait_cnt[d]--;
            trim_ring();
            if (conn_cnt[d] < 16'hFFFF) conn_cnt[d]++;
            add_result(V_RESUMED, wt, conn_cnt[d], wait_cnt[d]);
            n++;
          end while (conn_cnt[d] < conn_limit && wait_cnt[d] > 0 && n < MAX_OUT);
          if (n == 0) add_result(V_RELEASED, it.request_tag, conn_cnt[d], wait_cnt[d]);
        end
      end
      expected_q[expected_q.size() - 1].last = 1'b1;
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result verdict=%0d tag=%h",
                         got.verdict, got.affected_tag));
        return;
      end
      want = expected_q.pop_front();
      if (got.verdict != want.verdict || got.affected_tag != want.affected_tag ||
          got.active_now != want.active_now || got.waiting_now != want.waiting_now ||
          got.last != want.last)
        report($sformatf("got v=%0d tag=%h act=%0d wait=%0d last=%b, want v=%0d tag=%h act=%0d wait=%0d last=%b",
                         got.verdict, got.affected_tag, got.active_now, got.waiting_now,
                         got.last, want.verdict, want.affected_tag, want.active_now,
                         want.waiting_now, want.last));
    endtask
  endclass

  localparam int NUM_KEYS = 20;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  in_item_t    item_i;
  logic        empty;
  logic        pop;
  result_t     result_o;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [15:0] cfg_data_i;

  limiter_scoreboard conn_sb;

  // Idle percentages of both sides and the length of a forced receiver stall.
  int          send_idle;
  int          recv_stall;
  int          hold_cycles;
  logic [31:0] addr_pool[NUM_KEYS];
  logic [15:0] port_pool[NUM_KEYS];
  logic [15:0] recent_tags[$];

  per_destination_connection_limiter i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .item_i    (item_i),
    .empty     (empty),
    .pop       (pop),
    .result_o  (result_o),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Hard limit on the whole run; far above the slowest correct run.
  initial begin
    #200ms;
    $display("*** FAILED ***");
    $finish;
  end

  // Result side. The outputs only move at rising edges, so the values seen at
  // the falling edge are the ones that the next rising edge transfers.
  // A pending hold-off forces pop low while hold_cycles, counted down here, is nonzero.
  always begin
    result_t got;
    bit      taken;
    @(negedge clk_i);
    taken = rst_ni && pop && !empty;
    got = result_o;
    @(posedge clk_i);
    if (taken) conn_sb.check_result(got);
    if (hold_cycles > 0) begin
      hold_cycles--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_stall);
    end
  end

  // Offers one item and returns once it has been transferred. Push is left
  // high so that a following item can go out on the very next cycle; the
  // idle loop or the caller lowers it.
  task send_item(in_item_t it);
    bit ready;
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    item_i <= it;
    forever begin
      @(negedge clk_i);
      ready = !full;
      @(posedge clk_i);
      if (ready) break;
    end
    conn_sb.note_input(it);
    if (it.func == FUNC_REQUEST) begin
      recent_tags.push_back(it.request_tag);
      if (recent_tags.size() > 32) void'(recent_tags.pop_front());
    end
  endtask

  // Waits until every expected result has come back and the engine has had
  // time to settle, so that the registers can be changed safely.
  task drain();
    push <= 1'b0;
    while (conn_sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task write_limits(logic [15:0] conn_limit, logic [9:0] backlog);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_CONN_LIMIT;
    cfg_data_i <= conn_limit;
    @(posedge clk_i);
    cfg_idx_i <= CFG_BACKLOG;
    cfg_data_i <= {6'd0, backlog};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    conn_sb.set_reg(CFG_CONN_LIMIT, conn_limit);
    conn_sb.set_reg(CFG_BACKLOG, {6'd0, backlog});
  endtask

  function automatic in_item_t make_item(func_e f, int k, logic [15:0] tag);
    in_item_t it;
    it.func = f;
    it.dest_addr = addr_pool[k];
    it.dest_port = port_pool[k];
    it.request_tag = tag;
    return it;
  endfunction

  // Random traffic over the first num_keys destinations, req_pct percent of it
  // requests; cancels mostly name a tag that was requested.
  task random_items(int count, int num_keys, int req_pct);
    int          roll;
    func_e       f;
    logic [15:0] tag;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (roll < req_pct) f = FUNC_REQUEST;
      else if (roll < req_pct + (100 - req_pct) / 2) f = FUNC_RELEASE;
      else if (roll < req_pct + 3 * (100 - req_pct) / 4) f = FUNC_CANCEL;
      else f = FUNC_ABANDON;
      tag = 16'($urandom_range(16'hFFFF));
      if (f == FUNC_CANCEL && recent_tags.size() > 0 && $urandom_range(9) < 8)
        tag = recent_tags[$urandom_range(recent_tags.size() - 1)];
      send_item(make_item(f, $urandom_range(num_keys - 1), tag));
    end
  endtask

  initial begin
    conn_sb = new();
    conn_sb.clear();
    rst_ni = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    item_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_CONN_LIMIT;
    cfg_data_i = '0;
    send_idle = 0;
    recv_stall = 0;
    hold_cycles = 0;
    // Distinct keys: the low address bits carry the index, the rest is random.
    // The first two keys are the all-zero and all-one extremes.
    for (int k = 0; k < NUM_KEYS; k++) begin
      addr_pool[k] = $urandom;
      addr_pool[k][4:0] = 5'(k);
      port_pool[k] = 16'($urandom_range(16'hFFFF));
    end
    addr_pool[0] = '0;
    port_pool[0] = '0;
    addr_pool[1] = '1;
    port_pool[1] = '1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part under the reset limits (one connection, deep backlog).
    send_item(make_item(FUNC_REQUEST, 0, 16'h0000));   // admitted
    send_item(make_item(FUNC_REQUEST, 0, 16'hFFFF));   // queued
    send_item(make_item(FUNC_REQUEST, 0, 16'h0005));   // queued
    send_item(make_item(FUNC_CANCEL, 0, 16'h0005));    // cancelled, tail hole reclaimed
    send_item(make_item(FUNC_CANCEL, 0, 16'h0077));    // known destination, tag not queued
    send_item(make_item(FUNC_RELEASE, 1, 16'h0001));   // unknown destination
    send_item(make_item(FUNC_CANCEL, 1, 16'h0001));    // unknown destination
    send_item(make_item(FUNC_ABANDON, 1, 16'h0001));   // unknown destination
    send_item(make_item(FUNC_RELEASE, 0, 16'h0000));   // hands the slot to the waiter
    send_item(make_item(FUNC_ABANDON, 0, 16'hFFFF));   // released, no resume
    send_item(make_item(FUNC_RELEASE, 0, 16'h0000));   // release with no connection
    send_item(make_item(FUNC_REQUEST, 1, 16'hA5A5));   // new destination, all-ones key
    send_item(make_item(FUNC_REQUEST, 0, 16'h0009));
    send_item(make_item(FUNC_REQUEST, 0, 16'h0009));   // duplicate tags wait
    send_item(make_item(FUNC_REQUEST, 0, 16'h0009));
    send_item(make_item(FUNC_REQUEST, 0, 16'h0003));
    send_item(make_item(FUNC_CANCEL, 0, 16'h0009));    // oldest match goes, head hole
    send_item(make_item(FUNC_RELEASE, 0, 16'h5A5A));   // resumes the oldest remaining waiter
    drain();

    // Limit zero: requests get in only while nothing is active.
    write_limits(16'd0, 10'd1000);
    random_items(20, 4, 45);
    drain();

    // Widest limit and no backlog at all; the sender idles most cycles.
    write_limits(16'hFFFF, 10'd0);
    send_idle = 70;
    random_items(20, 6, 50);
    drain();

    // Small limits; the receiver stalls often and first holds off for a long
    // stretch while the sender keeps offering, so both queues fill up.
    write_limits(16'd3, 10'd2);
    send_idle = 0;
    recv_stall = 70;
    hold_cycles = 400;
    random_items(26, 5, 55);
    drain();

    // One connection, deepest backlog: heavy requests on one key fill the
    // shared ring until requests are dropped; a release-heavy run follows.
    write_limits(16'd1, 10'd1023);
    send_idle = 10;
    recv_stall = 10;
    random_items(70, 1, 94);
    random_items(12, 1, 20);
    drain();

    // All keys in play so that the table runs full; no idling.
    write_limits(16'd2, 10'd1);
    send_idle = 0;
    recv_stall = 0;
    random_items(24, NUM_KEYS, 80);
    drain();

    if (conn_sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire

[per_destination_connection_limiter.f]
hw/rtl/pcl_pkg.sv
hw/rtl/pcl_front.sv
hw/rtl/pcl_outq.sv
hw/rtl/pcl_engine.sv
hw/rtl/per_destination_connection_limiter.sv
verif/tb_per_destination_connection_limiter.sv
